FILE: sv/pms_pkg.sv
// Shared types, codes and constants for the proximity motor supervisor.
// Used by pms_duty, pms_ctrl, pms_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pms_pkg;

	// Field and register widths
	localparam int unsigned TIME_W     = 32;
	localparam int unsigned PERIOD_W   = 27;
	localparam int unsigned TRIG_W     = 16;
	localparam int unsigned ADC_W      = 16;
	localparam int unsigned MODE_W     = 2;
	localparam int unsigned CODE_W     = 3;
	localparam int unsigned ZONE_W     = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MOTOR_PERIOD     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BUZZ_NEAR_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BUZZ_FAR_PERIOD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_HIGH     = 3'd5;

	// Configuration reset values
	localparam logic [PERIOD_W-1:0] MOTOR_PERIOD_RST     = 27'd166666;
	localparam logic [TIME_W-1:0]   NEAR_LIMIT_RST       = 32'd37000;
	localparam logic [TIME_W-1:0]   FAR_LIMIT_RST        = 32'd111000;
	localparam logic [TIME_W-1:0]   BUZZ_NEAR_PERIOD_RST = 32'd300000;
	localparam logic [TIME_W-1:0]   BUZZ_FAR_PERIOD_RST  = 32'd1000000;
	localparam logic [TRIG_W-1:0]   TRIGGER_HIGH_RST     = 16'd15000;

	// Item kinds
	localparam logic [MODE_W-1:0] MODE_ECHO_START = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ECHO_END   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BUTTON     = 2'd2;
	localparam logic [MODE_W-1:0] MODE_TICK       = 2'd3;

	// Button codes
	localparam logic [CODE_W-1:0] BTN_RESET = 3'd1;
	localparam logic [CODE_W-1:0] BTN_MODE  = 3'd2;
	localparam logic [CODE_W-1:0] BTN_PAUSE = 3'd4;

	// Zones
	localparam logic [ZONE_W-1:0] ZONE_CLEAR  = 2'd0;
	localparam logic [ZONE_W-1:0] ZONE_SLOW   = 2'd1;
	localparam logic [ZONE_W-1:0] ZONE_ESTOP  = 2'd2;
	localparam logic [ZONE_W-1:0] ZONE_PAUSED = 2'd3;

	// Motor duty: 34 + floor(adc*12/10000) percent of the period
	localparam int unsigned DUTY_W    = 7;
	localparam logic [DUTY_W-1:0] DUTY_BASE = 7'd34;
	// floor(3*adc/2500) as (3*adc * ceil(2^30/2500)) >> 30, exact for 18-bit inputs
	localparam int unsigned ADC_X3_W      = ADC_W + 2;
	localparam int unsigned ADC_RECIP_W   = 19;
	localparam logic [ADC_RECIP_W-1:0] ADC_RECIP = 19'd429497;
	localparam int unsigned ADC_SHIFT     = 30;
	localparam int unsigned ADC_PROD_W    = ADC_X3_W + ADC_RECIP_W;
	// floor(p/100) as floor((p>>2)/25), then (u * ceil(2^36/25)) >> 36, exact for 32-bit u
	localparam int unsigned PROD_W        = PERIOD_W + DUTY_W;
	localparam logic [TIME_W-1:0] PCT_RECIP = 32'd2748779070;
	localparam int unsigned PCT_SHIFT     = 36;
	localparam int unsigned PCT_PROD_W    = 2 * TIME_W;
	localparam int unsigned QUOT_W        = PCT_PROD_W - PCT_SHIFT;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_COMMIT
	} ctrl_state_t;

	typedef struct packed {
		logic load;
		logic commit;
	} pms_cmd_t;

	typedef struct packed {
		logic in_tick;
		logic slot_free;
	} pms_sts_t;

endpackage

`default_nettype wire

FILE: sv/proximity_motor_supervisor.sv
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+---------------------------------------------
// cfg      | in        | cfg_we               | cfg_index, cfg_data
// in       | in        | in_valid / in_ready  | mode, timestamp, button_code, adc_sample
// out      | out       | out_valid / out_ready| buzzer_period, buzzer_high, motor_high,
//          |           |                      | trigger_high_res, zone, motor_mode, reset_request
//
// Echo and button items go straight from accept to commit; a control tick first
// passes ST_MUL1, ST_MUL2 and ST_MUL3, set by the three registered multiplies of the motor duty unit.
// One item is in flight at a time; a new beat is accepted while a result waits.
// The commit waits while the previous result is still unclaimed by out_ready.
// Reset loads the default configuration and supervisor state; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module proximity_motor_supervisor (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [pms_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pms_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [pms_pkg::MODE_W-1:0]      mode,
	input  wire logic [pms_pkg::TIME_W-1:0]      timestamp,
	input  wire logic [pms_pkg::CODE_W-1:0]      button_code,
	input  wire logic [pms_pkg::ADC_W-1:0]       adc_sample,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [pms_pkg::TIME_W-1:0]      buzzer_period,
	output logic      [pms_pkg::TIME_W-1:0]      buzzer_high,
	output logic      [pms_pkg::TIME_W-1:0]      motor_high,
	output logic      [pms_pkg::TRIG_W-1:0]      trigger_high_res,
	output logic      [pms_pkg::ZONE_W-1:0]      zone,
	output logic                                 motor_mode,
	output logic                                 reset_request
);
	import pms_pkg::*;

	pms_cmd_t cmd;
	pms_sts_t sts;

	pms_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	pms_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mode             (mode),
		.timestamp        (timestamp),
		.button_code      (button_code),
		.adc_sample       (adc_sample),
		.cmd              (cmd),
		.sts              (sts),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.buzzer_period    (buzzer_period),
		.buzzer_high      (buzzer_high),
		.motor_high       (motor_high),
		.trigger_high_res (trigger_high_res),
		.zone             (zone),
		.motor_mode       (motor_mode),
		.reset_request    (reset_request)
	);

endmodule

`default_nettype wire

FILE: sv/pms_duty.sv
// Motor high-time unit: three-stage multiply chain for period*duty/100.
// Depends on pms_pkg for widths and reciprocal constants.
`timescale 1ns / 1ps
`default_nettype none

module pms_duty (
	input  wire logic                          clk,
	input  wire logic [pms_pkg::ADC_W-1:0]     adc_sample,
	input  wire logic [pms_pkg::PERIOD_W-1:0]  motor_period,
	output logic      [pms_pkg::TIME_W-1:0]    motor_high
);
	import pms_pkg::*;

	logic [ADC_X3_W-1:0]   adc_x3;
	logic [ADC_PROD_W-1:0] scale_prod;
	logic [DUTY_W-1:0]     duty_s1;
	logic [PROD_W-1:0]     period_prod_s2;
	logic [PCT_PROD_W-1:0] pct_prod;
	logic [QUOT_W-1:0]     quot_s3;

	assign adc_x3     = {2'b00, adc_sample} + {1'b0, adc_sample, 1'b0};
	assign scale_prod = ADC_PROD_W'(adc_x3) * ADC_PROD_W'(ADC_RECIP);
	assign pct_prod   = PCT_PROD_W'(period_prod_s2[PROD_W-1:2]) * PCT_PROD_W'(PCT_RECIP);

	always_ff @(posedge clk) begin
		duty_s1        <= DUTY_BASE + scale_prod[ADC_PROD_W-1:ADC_SHIFT];
		period_prod_s2 <= PROD_W'(motor_period) * PROD_W'(duty_s1);
		quot_s3        <= pct_prod[PCT_PROD_W-1:PCT_SHIFT];
	end

	// 27-bit period times duty of at most 112 stays below 2^28 after /100: no saturation
	assign motor_high = TIME_W'(quot_s3);

endmodule

`default_nettype wire

FILE: sv/pms_ctrl.sv
// Sequencer for the supervisor: accepts one item, waits out the duty
// multiply chain on ticks and commits when the result slot is free. Uses pms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pms_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire pms_pkg::pms_sts_t sts,
	output pms_pkg::pms_cmd_t      cmd
);
	import pms_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.in_tick ? ST_MUL1 : ST_COMMIT;
				end
			end
			ST_MUL1:   state_d = ST_MUL2;
			ST_MUL2:   state_d = ST_MUL3;
			ST_MUL3:   state_d = ST_COMMIT;
			ST_COMMIT: begin
				if (sts.slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_COMMIT: cmd.commit = sts.slot_free;
			default: ;
		endcase
	end

	// a tick walks the full multiply chain before it may commit
	a_tick_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && in_valid && sts.in_tick)
		|=> state_q == ST_MUL1 ##1 state_q == ST_MUL2 ##1 state_q == ST_MUL3)
		else $error("tick skipped a multiply stage");

endmodule

`default_nettype wire

FILE: sv/pms_datapath.sv
// Datapath: configuration registers, item capture, supervisor state that
// doubles as the result register, and the duty unit. Uses pms_pkg and pms_duty.
`timescale 1ns / 1ps
`default_nettype none

module pms_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [pms_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [pms_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic [pms_pkg::MODE_W-1:0]      mode,
	input  wire logic [pms_pkg::TIME_W-1:0]      timestamp,
	input  wire logic [pms_pkg::CODE_W-1:0]      button_code,
	input  wire logic [pms_pkg::ADC_W-1:0]       adc_sample,
	input  wire pms_pkg::pms_cmd_t               cmd,
	output pms_pkg::pms_sts_t                    sts,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [pms_pkg::TIME_W-1:0]      buzzer_period,
	output logic      [pms_pkg::TIME_W-1:0]      buzzer_high,
	output logic      [pms_pkg::TIME_W-1:0]      motor_high,
	output logic      [pms_pkg::TRIG_W-1:0]      trigger_high_res,
	output logic      [pms_pkg::ZONE_W-1:0]      zone,
	output logic                                 motor_mode,
	output logic                                 reset_request
);
	import pms_pkg::*;

	// configuration
	logic [PERIOD_W-1:0] motor_period_q;
	logic [TIME_W-1:0]   near_limit_q;
	logic [TIME_W-1:0]   far_limit_q;
	logic [TIME_W-1:0]   buzz_near_q;
	logic [TIME_W-1:0]   buzz_far_q;
	logic [TRIG_W-1:0]   trigger_cfg_q;

	// captured item
	logic [MODE_W-1:0] item_mode_q;
	logic [TIME_W-1:0] item_ts_q;
	logic [CODE_W-1:0] item_code_q;
	logic [ADC_W-1:0]  item_adc_q;

	// supervisor state
	logic [TIME_W-1:0] echo_start_q, echo_start_d;
	logic [TIME_W-1:0] echo_width_q, echo_width_d;
	logic              paused_q, paused_d;
	logic              pending_q, pending_d;
	logic              motor_mode_q, motor_mode_d;
	logic [TIME_W-1:0] buzzer_period_q, buzzer_period_d;
	logic [TIME_W-1:0] buzzer_high_q, buzzer_high_d;
	logic [TIME_W-1:0] motor_high_q, motor_high_d;
	logic [TRIG_W-1:0] trigger_q, trigger_d;
	logic [ZONE_W-1:0] zone_q, zone_d;
	logic              req_q, req_d;
	logic              out_valid_q;

	logic [TIME_W-1:0] duty_time;

	pms_duty u_duty (
		.clk          (clk),
		.adc_sample   (item_adc_q),
		.motor_period (motor_period_q),
		.motor_high   (duty_time)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_period_q <= MOTOR_PERIOD_RST;
			near_limit_q   <= NEAR_LIMIT_RST;
			far_limit_q    <= FAR_LIMIT_RST;
			buzz_near_q    <= BUZZ_NEAR_PERIOD_RST;
			buzz_far_q     <= BUZZ_FAR_PERIOD_RST;
			trigger_cfg_q  <= TRIGGER_HIGH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MOTOR_PERIOD:     motor_period_q <= cfg_data[PERIOD_W-1:0];
				REG_NEAR_LIMIT:       near_limit_q   <= cfg_data[TIME_W-1:0];
				REG_FAR_LIMIT:        far_limit_q    <= cfg_data[TIME_W-1:0];
				REG_BUZZ_NEAR_PERIOD: buzz_near_q    <= cfg_data[TIME_W-1:0];
				REG_BUZZ_FAR_PERIOD:  buzz_far_q     <= cfg_data[TIME_W-1:0];
				REG_TRIGGER_HIGH:     trigger_cfg_q  <= cfg_data[TRIG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_mode_q <= mode;
			item_ts_q   <= timestamp;
			item_code_q <= button_code;
			item_adc_q  <= adc_sample;
		end
	end

	always_comb begin
		echo_start_d    = echo_start_q;
		echo_width_d    = echo_width_q;
		paused_d        = paused_q;
		pending_d       = pending_q;
		motor_mode_d    = motor_mode_q;
		buzzer_period_d = buzzer_period_q;
		buzzer_high_d   = buzzer_high_q;
		motor_high_d    = motor_high_q;
		trigger_d       = trigger_q;
		zone_d          = zone_q;
		req_d           = 1'b0;
		unique case (item_mode_q)
			MODE_ECHO_START: echo_start_d = item_ts_q;
			MODE_ECHO_END:   echo_width_d = item_ts_q - echo_start_q;
			MODE_BUTTON: begin
				motor_high_d = '0;
				case (item_code_q)
					BTN_RESET: begin
						req_d           = 1'b1;
						buzzer_period_d = '0;
						buzzer_high_d   = buzz_far_q >> 1;
						trigger_d       = trigger_cfg_q;
					end
					BTN_MODE:  pending_d = 1'b1;
					BTN_PAUSE: begin
						paused_d  = !paused_q;
						trigger_d = paused_q ? trigger_cfg_q : '0;
					end
					default: ;
				endcase
			end
			MODE_TICK: begin
				if (paused_q) begin
					buzzer_period_d = '0;
					zone_d          = ZONE_PAUSED;
				end else if (echo_width_q < near_limit_q) begin
					// estop: motor off, mode machine holds
					buzzer_period_d = buzz_near_q;
					buzzer_high_d   = buzz_near_q >> 1;
					motor_high_d    = '0;
					zone_d          = ZONE_ESTOP;
				end else begin
					if (echo_width_q < far_limit_q) begin
						buzzer_period_d = buzz_far_q;
						buzzer_high_d   = buzz_far_q >> 1;
						zone_d          = ZONE_SLOW;
					end else begin
						buzzer_period_d = '0;
						zone_d          = ZONE_CLEAR;
					end
					if (motor_mode_q) begin
						motor_high_d = duty_time;
						if (pending_q) begin
							motor_mode_d = 1'b0;
							pending_d    = 1'b0;
						end
					end else if (pending_q) begin
						motor_mode_d = 1'b1;
						pending_d    = 1'b0;
					end
				end
			end
			default: ;
		endcase
	end

	// state only advances on commit, so it also serves as the held result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_start_q    <= '0;
			echo_width_q    <= '0;
			paused_q        <= 1'b0;
			pending_q       <= 1'b0;
			motor_mode_q    <= 1'b0;
			buzzer_period_q <= '0;
			buzzer_high_q   <= BUZZ_FAR_PERIOD_RST >> 1;
			motor_high_q    <= '0;
			trigger_q       <= TRIGGER_HIGH_RST;
			zone_q          <= ZONE_CLEAR;
			req_q           <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cmd.commit) begin
				echo_start_q    <= echo_start_d;
				echo_width_q    <= echo_width_d;
				paused_q        <= paused_d;
				pending_q       <= pending_d;
				motor_mode_q    <= motor_mode_d;
				buzzer_period_q <= buzzer_period_d;
				buzzer_high_q   <= buzzer_high_d;
				motor_high_q    <= motor_high_d;
				trigger_q       <= trigger_d;
				zone_q          <= zone_d;
				req_q           <= req_d;
				out_valid_q     <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.in_tick   = (mode == MODE_TICK);
	assign sts.slot_free = !out_valid_q || out_ready;

	assign out_valid        = out_valid_q;
	assign buzzer_period    = buzzer_period_q;
	assign buzzer_high      = buzzer_high_q;
	assign motor_high       = motor_high_q;
	assign trigger_high_res = trigger_q;
	assign zone             = zone_q;
	assign motor_mode       = motor_mode_q;
	assign reset_request    = req_q;

	a_hold_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready)
		|=> $stable({buzzer_period_q, buzzer_high_q, motor_high_q, trigger_q,
			zone_q, motor_mode_q, req_q}))
		else $error("state changed under a waiting result");

	a_estop_motor_off: assert property (@(posedge clk) disable iff (!arst_n)
		(zone_q == ZONE_ESTOP) |-> (motor_high_q == '0))
		else $error("motor running in estop zone");

	a_req_only_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && !(item_mode_q == MODE_BUTTON && item_code_q == BTN_RESET))
		|=> !req_q)
		else $error("reset request on a non-reset item");

endmodule

`default_nettype wire
